FILE: hw/rtl/serial_speech_rom_reader_defines.svh
// Assertion macros used by the serial speech ROM reader RTL.
`ifndef SERIAL_SPEECH_ROM_READER_DEFINES_SVH
`define SERIAL_SPEECH_ROM_READER_DEFINES_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define SSRR_ASSERT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSRR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SSRR_ASSERT(lbl, clk, rst, ante, cons, msg)
`define SSRR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/ssrr_pkg.sv
// Shared types and constants for the serial speech ROM reader.
`default_nettype none

package ssrr_pkg;

   localparam int ROM_DEPTH_DEFAULT = 32768;

   localparam int ADDR_W  = 18;
   localparam int LIMIT_W = 19;
   localparam int LEN_W   = 16;

   localparam logic [LEN_W-1:0]  ROM_LENGTH_RESET = 16'd32768;
   localparam logic [4:0]        NIBBLE_MAX_POS   = 5'd20;
   localparam logic [4:0]        NIBBLE_STEP      = 5'd4;
   localparam logic [3:0]        BITS_PER_BYTE    = 4'd8;
   localparam logic [ADDR_W-1:0] BRANCH_KEEP      = 18'h3C000;
   localparam logic [ADDR_W-1:0] BRANCH_LOW       = 18'h03FFF;

   // Register index as decoded from the word address bit of the bus.
   localparam logic CSR_ROM_LENGTH = 1'b0;

   typedef enum logic [1:0] {
      MODE_WRITE  = 2'd0,
      MODE_LOAD   = 2'd1,
      MODE_READ   = 2'd2,
      MODE_BRANCH = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH_LO,
      ST_EXEC
   } ctrl_state_type;

   typedef struct packed {
      logic accept;    // capture the incoming item
      logic latch_lo;  // first ROM byte is on the read port
      logic rd_next;   // read port addresses the following byte
      logic exec;      // commit the item and load the result register
   } cmd_type;

   typedef struct packed {
      logic req_reads_rom;
   } status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ssrr_ctrl.sv
// Controller state machine of the serial speech ROM reader.
`default_nettype none

module ssrr_ctrl import ssrr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.req_reads_rom ? ST_FETCH_LO : ST_EXEC;
            end
         end
         ST_FETCH_LO: begin
            cmd.latch_lo = 1'b1;
            cmd.rd_next  = 1'b1;
            state_in     = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.rd_next = 1'b1;
            if (slot_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/ssrr_datapath.sv
// Datapath of the serial speech ROM reader: ROM store, address state and result register.
`default_nettype none

module ssrr_datapath import ssrr_pkg::*; #(
   parameter int ROM_DEPTH = ROM_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output status_type             status,
   input  wire logic [1:0]        req_mode,
   input  wire logic [14:0]       req_rom_index,
   input  wire logic [7:0]        req_rom_byte,
   input  wire logic [3:0]        req_nibble,
   input  wire logic [3:0]        req_bit_count,
   input  wire logic [LEN_W-1:0]  rom_length,
   output logic [7:0]             rsp_read_bits,
   output logic [ADDR_W-1:0]      rsp_current_address
);

   localparam int IDX_W = $clog2(ROM_DEPTH);
   localparam logic [LIMIT_W-1:0] DEPTH_LIM = LIMIT_W'(ROM_DEPTH);

   logic [7:0] mem [ROM_DEPTH];

   mode_type            mode_ff;
   logic [14:0]         index_ff;
   logic [7:0]          byte_ff;
   logic [3:0]          nibble_ff;
   logic [3:0]          count_ff;

   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [4:0]          pos_ff, pos_in;
   logic [3:0]          bits_left_ff, bits_left_in;

   logic [7:0]          byte_lo_ff;
   logic [7:0]          rd_data_ff;
   logic [IDX_W-1:0]    rd_idx;

   logic [7:0]          rsp_read_bits_ff;
   logic [ADDR_W-1:0]   rsp_current_address_ff;
   logic [7:0]          bits_in;

   logic [LIMIT_W-1:0]  limit;
   logic [LIMIT_W-1:0]  addr_ext;
   logic [LIMIT_W-1:0]  addr_nxt;
   logic                lo_ok;
   logic                hi_ok;
   logic [7:0]          b0;
   logic [7:0]          b1;
   logic                wr_in_range;

   assign status.req_reads_rom = (mode_type'(req_mode) == MODE_READ) ||
                                 (mode_type'(req_mode) == MODE_BRANCH);

   assign limit    = ({3'd0, rom_length} < DEPTH_LIM) ? {3'd0, rom_length} : DEPTH_LIM;
   assign addr_ext = {1'b0, addr_ff};
   assign addr_nxt = addr_ext + 1'b1;
   assign lo_ok    = addr_ext < limit;
   assign hi_ok    = addr_nxt < limit;
   assign b0       = lo_ok ? byte_lo_ff : 8'd0;
   assign b1       = hi_ok ? rd_data_ff : 8'd0;

   assign wr_in_range = {4'd0, index_ff} < DEPTH_LIM;
   assign rd_idx      = cmd.rd_next ? IDX_W'(addr_nxt) : IDX_W'(addr_ff);

   // Store with a write port and a separate read port; read data is registered.
   always_ff @(posedge clock) begin
      if (cmd.exec && (mode_ff == MODE_WRITE) && wr_in_range) begin
         mem[IDX_W'(index_ff)] <= byte_ff;
      end
      rd_data_ff <= mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff   <= mode_type'(req_mode);
         index_ff  <= req_rom_index;
         byte_ff   <= req_rom_byte;
         nibble_ff <= req_nibble;
         count_ff  <= req_bit_count;
      end
      if (cmd.latch_lo) begin
         byte_lo_ff <= rd_data_ff;
      end
      if (cmd.exec) begin
         rsp_read_bits_ff       <= bits_in;
         rsp_current_address_ff <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         pos_ff       <= '0;
         bits_left_ff <= '0;
      end else if (cmd.exec) begin
         addr_ff      <= addr_in;
         pos_ff       <= pos_in;
         bits_left_ff <= bits_left_in;
      end
   end

   always_comb begin
      logic [23:0]       ld_wide;
      logic [3:0]        cnt;
      logic [7:0]        mask;
      logic [3:0]        bl_new;
      logic [15:0]       word;
      logic [ADDR_W-1:0] word_ext;

      addr_in      = addr_ff;
      pos_in       = pos_ff;
      bits_left_in = bits_left_ff;
      bits_in      = 8'd0;

      ld_wide  = ({6'd0, addr_ff} & ~(24'hF << pos_ff)) | (24'(nibble_ff) << pos_ff);
      cnt      = (count_ff > BITS_PER_BYTE) ? BITS_PER_BYTE : count_ff;
      if ((pos_ff != 5'd0) && (cnt != 4'd0)) begin
         cnt = cnt - 4'd1;
      end
      mask     = 8'hFF >> (BITS_PER_BYTE - cnt);
      word     = {b0, b1};
      word_ext = {2'd0, word};
      bl_new   = 4'd0;

      unique case (mode_ff)
         MODE_WRITE: begin
         end
         MODE_LOAD: begin
            addr_in      = ld_wide[ADDR_W-1:0];
            pos_in       = (pos_ff < NIBBLE_MAX_POS) ? pos_ff + NIBBLE_STEP : pos_ff;
            bits_left_in = BITS_PER_BYTE;
         end
         MODE_READ: begin
            pos_in = 5'd0;
            if (lo_ok) begin
               if (cnt < bits_left_ff) begin
                  bl_new  = bits_left_ff - cnt;
                  bits_in = (b0 >> bl_new) & mask;
               end else begin
                  // The read runs into the next byte.
                  bl_new  = 4'(bits_left_ff + BITS_PER_BYTE - cnt);
                  bits_in = 8'(word >> bl_new) & mask;
                  addr_in = addr_nxt[ADDR_W-1:0];
               end
               bits_left_in = bl_new;
            end
         end
         MODE_BRANCH: begin
            addr_in      = (addr_ff & BRANCH_KEEP) | (word_ext & BRANCH_LOW);
            bits_left_in = BITS_PER_BYTE;
         end
         default: begin
         end
      endcase
   end

   assign rsp_read_bits       = rsp_read_bits_ff;
   assign rsp_current_address = rsp_current_address_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/serial_speech_rom_reader.sv
// Top level of the serial speech ROM reader.
// Usage: items arrive on the req_ channel with a valid/ready transfer. The mode
// field picks one of four operations: write a byte into the ROM store, shift an
// address nibble into the 18-bit address, read 0 to 8 bits MSB first, or read a
// big-endian word at the address and load its low 14 bits into the address.
// Every item yields exactly one result transfer on the rsp_ channel, carrying
// the bits read and the address after the item.
// Sequence: write and load items go from the transfer to the execute state and
// back to idle, where ready is high; read and branch items pass a fetch state
// first, since the ROM store has registered read data and must deliver two
// bytes one after the other. The result register is loaded, and the result
// made valid, as the execute state commits the item.
// The result sits in an output register, so a new item is taken while the last
// result still waits; if the receiver stalls, the following item waits in its
// final step until the output register is free.
// Reset (synchronous, active high) clears the address, nibble position, bit
// position and the result valid, and sets rom_length to 32768. ROM contents are
// undefined until written. rom_length is written over the APB port at address 0.
`default_nettype none
`include "serial_speech_rom_reader_defines.svh"

module serial_speech_rom_reader import ssrr_pkg::*; #(
   parameter int ROM_DEPTH = ROM_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_mode,
   input  wire logic [14:0]       req_rom_index,
   input  wire logic [7:0]        req_rom_byte,
   input  wire logic [3:0]        req_nibble,
   input  wire logic [3:0]        req_bit_count,

   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_read_bits,
   output logic [ADDR_W-1:0]      rsp_current_address,

   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   cmd_type          dp_cmd;
   status_type       dp_status;
   logic [LEN_W-1:0] rom_length_ff;
   logic             csr_write;

   // The register file is a single word; paddr[2] tells it apart from the
   // unused word above it, and the byte lane bits are ignored.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == CSR_ROM_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_length_ff <= ROM_LENGTH_RESET;
      end else if (csr_write) begin
         rom_length_ff <= pwdata[LEN_W-1:0];
      end
   end

   assign prdata = (paddr[2] == CSR_ROM_LENGTH) ? {16'd0, rom_length_ff} : 32'd0;

   // The controller sequences each item; the datapath holds the store and state.
   ssrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   ssrr_datapath #(
      .ROM_DEPTH (ROM_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (dp_cmd),
      .status              (dp_status),
      .req_mode            (req_mode),
      .req_rom_index       (req_rom_index),
      .req_rom_byte        (req_rom_byte),
      .req_nibble          (req_nibble),
      .req_bit_count       (req_bit_count),
      .rom_length          (rom_length_ff),
      .rsp_read_bits       (rsp_read_bits),
      .rsp_current_address (rsp_current_address)
   );

   // After a transfer in, the block is not ready in the following cycle.
   `SSRR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "busy")
   // An item commits only when the result register is free to take it.
   `SSRR_ASSERT(a_exec_slot_free, clock, reset, dp_cmd.exec, !rsp_valid || rsp_ready, "overwrite")
   // A result appears only as the commit of an item.
   `SSRR_ASSERT(a_rsp_from_exec, clock, reset, $rose(rsp_valid), $past(dp_cmd.exec), "no item")

endmodule

`default_nettype wire

FILE: bench/serial_speech_rom_reader_test.sv
// Self-checking testbench for the serial speech ROM reader, with its own predictor.
`timescale 1ns / 100ps

module serial_speech_rom_reader_test import ssrr_pkg::*; ();

   // The rom_length register sits at byte address 4 * index on the APB port.
   localparam logic [2:0] LENGTH_ADDR = {CSR_ROM_LENGTH, 2'b00};

   // Generous watchdog limit on the length of a run.
   localparam int unsigned CYCLE_LIMIT = 400_000;

   // Cap on the mismatch lines so that a broken design cannot flood the log.
   localparam int unsigned REPORT_CAP = 200;

   localparam int unsigned STORE_DEPTH = ROM_DEPTH_DEFAULT;

   typedef struct {
      mode_type    mode;
      logic [14:0] rom_index;
      logic [7:0]  rom_byte;
      logic [3:0]  nibble;
      logic [3:0]  bit_count;
   } req_item_type;

   typedef struct {
      logic [7:0]        read_bits;
      logic [ADDR_W-1:0] current_address;
   } rsp_item_type;

   // The scoreboard keeps a full copy of the reader state: the byte store, the
   // serial address, the nibble position and the bits still unread in the
   // current byte. Each accepted request advances that copy and queues the
   // response that the reader must give for it.
   class rom_reader_scoreboard;
      logic [7:0]        store [ROM_DEPTH_DEFAULT];
      bit                written [ROM_DEPTH_DEFAULT];
      logic [ADDR_W-1:0] address = '0;
      logic [4:0]        nib_pos = '0;
      logic [3:0]        bits_left = '0;
      logic [LEN_W-1:0]  rom_length = ROM_LENGTH_RESET;
      rsp_item_type      pending_results [$];
      int unsigned       errors = 0;
      int unsigned       checked = 0;
      int unsigned       mode_count [4] = '{0, 0, 0, 0};

      function void complain(input string msg);
         errors++;
         if (errors <= REPORT_CAP)
            $display("%0t: mismatch, %s", $time, msg);
      endfunction

      function int unsigned limit();
         return (32'(rom_length) < STORE_DEPTH) ? 32'(rom_length) : STORE_DEPTH;
      endfunction

      // Bytes at or past the limit read as zero.
      function int unsigned fetch(input int unsigned a);
         return (a < limit()) ? 32'(store[a]) : 32'd0;
      endfunction

      function logic [7:0] read_bits(input logic [3:0] req);
         int unsigned count, mask, val, left;
         count = (req > 4'd8) ? 32'd8 : 32'(req);
         // The first read after a load loses one bit of its request.
         if (nib_pos != 5'd0) begin
            nib_pos = '0;
            if (count > 0)
               count--;
         end
         if (32'(address) >= limit())
            return 8'h00;
         mask = 32'hFF >> (32'd8 - count);
         left = 32'(bits_left);
         if (count < left) begin
            left -= count;
            val = (fetch(32'(address)) >> left) & mask;
         end else begin
            // The request runs into the following byte.
            val = fetch(32'(address)) << 8;
            address = address + 18'd1;
            val |= fetch(32'(address));
            left = left + 32'd8 - count;
            val = (val >> left) & mask;
         end
         bits_left = left[3:0];
         return val[7:0];
      endfunction

      function void load_nibble(input logic [3:0] nib);
         int unsigned sh, a;
         sh = 32'(nib_pos);
         a = 32'(address);
         a = (a & ~(32'hF << sh)) | (32'(nib) << sh);
         address = a[ADDR_W-1:0];
         if (nib_pos < NIBBLE_MAX_POS)
            nib_pos = nib_pos + NIBBLE_STEP;
         bits_left = BITS_PER_BYTE;
      endfunction

      function void take_branch();
         int unsigned a, lim, word;
         a = 32'(address);
         lim = limit();
         if (a + 1 < lim)
            word = (fetch(a) << 8) | fetch(a + 1);
         else if (a + 1 == lim)
            word = fetch(a) << 8;
         else
            word = 0;
         address = (address & BRANCH_KEEP) | (word[ADDR_W-1:0] & BRANCH_LOW);
         bits_left = BITS_PER_BYTE;
      endfunction

      // Finds a store entry that the given request would fetch but that was
      // never written, so the stimulus can fill it first.
      function bit find_unwritten(input mode_type m, input logic [3:0] req,
                                  output int unsigned idx);
         int unsigned count, a, lim;
         int unsigned need [$];
         a = 32'(address);
         lim = limit();
         idx = 0;
         if (m == MODE_READ) begin
            count = (req > 4'd8) ? 32'd8 : 32'(req);
            if (nib_pos != 5'd0 && count > 0)
               count--;
            if (a < lim) begin
               need.push_back(a);
               if (count >= 32'(bits_left) && a + 1 < lim)
                  need.push_back(a + 1);
            end
         end else if (m == MODE_BRANCH) begin
            if (a < lim)
               need.push_back(a);
            if (a + 1 < lim)
               need.push_back(a + 1);
         end
         foreach (need[i]) begin
            if (!written[need[i]]) begin
               idx = need[i];
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_transfer(input req_item_type it);
         rsp_item_type r;
         r.read_bits = 8'h00;
         mode_count[int'(it.mode)]++;
         case (it.mode)
            MODE_WRITE: begin
               store[it.rom_index] = it.rom_byte;
               written[it.rom_index] = 1'b1;
            end
            MODE_LOAD:  load_nibble(it.nibble);
            MODE_READ:  r.read_bits = read_bits(it.bit_count);
            default:    take_branch();
         endcase
         r.current_address = address;
         pending_results.push_back(r);
      endfunction

      function void check_transfer(input logic [7:0] bits, input logic [ADDR_W-1:0] addr);
         rsp_item_type e;
         if (pending_results.size() == 0) begin
            complain($sformatf("response with nothing expected: read_bits %02h address %05h",
                               bits, addr));
            return;
         end
         e = pending_results.pop_front();
         checked++;
         if (bits !== e.read_bits)
            complain($sformatf("read_bits expected %02h actual %02h", e.read_bits, bits));
         if (addr !== e.current_address)
            complain($sformatf("current_address expected %05h actual %05h",
                               e.current_address, addr));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_mode = MODE_WRITE;
   logic [14:0]       req_rom_index = '0;
   logic [7:0]        req_rom_byte = '0;
   logic [3:0]        req_nibble = '0;
   logic [3:0]        req_bit_count = '0;

   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [7:0]        rsp_read_bits;
   logic [ADDR_W-1:0] rsp_current_address;

   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [2:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   rom_reader_scoreboard sb = new;

   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned settings_used = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   serial_speech_rom_reader #(
      .ROM_DEPTH(ROM_DEPTH_DEFAULT)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_rom_index       (req_rom_index),
      .req_rom_byte        (req_rom_byte),
      .req_nibble          (req_nibble),
      .req_bit_count       (req_bit_count),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_read_bits       (rsp_read_bits),
      .rsp_current_address (rsp_current_address),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Response side: every edge that completes a transfer is checked against the
   // oldest expectation, and ready is redrawn for the next cycle according to
   // the stall rate of the current phase.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_transfer(rsp_read_bits, rsp_current_address);
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: a hung handshake or a missing response ends the run here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL serial_speech_rom_reader");
      $finish;
   end

   function automatic req_item_type random_item(input mode_type m);
      req_item_type it;
      it.mode = m;
      it.rom_index = 15'($urandom_range(32767));
      it.rom_byte = 8'($urandom_range(255));
      it.nibble = 4'($urandom_range(15));
      it.bit_count = 4'($urandom_range(15));
      return it;
   endfunction

   // Builds a request whose meaningful fields are given; the fields that the
   // mode does not use carry random values.
   function automatic req_item_type make(input mode_type m, input logic [14:0] idx,
                                         input logic [7:0] val);
      req_item_type it;
      it = random_item(m);
      case (m)
         MODE_WRITE: begin
            it.rom_index = idx;
            it.rom_byte = val;
         end
         MODE_LOAD: it.nibble = val[3:0];
         MODE_READ: it.bit_count = val[3:0];
         default: ;
      endcase
      return it;
   endfunction

   // Mostly reads with legal bit counts and a share of oversized requests; one in ten is a branch.
   function automatic req_item_type read_or_branch();
      req_item_type it;
      if ($urandom_range(9) == 0)
         return random_item(MODE_BRANCH);
      it = random_item(MODE_READ);
      if ($urandom_range(99) < 85)
         it.bit_count = 4'($urandom_range(8));
      return it;
   endfunction

   // Address targets cluster at the bottom of the store and around the current
   // limit, where reads cross into bytes that no longer count.
   function automatic int unsigned pick_target();
      int unsigned lim, r;
      lim = sb.limit();
      r = $urandom_range(99);
      if (r < 30)
         return $urandom_range(63);
      if (r < 55)
         return (lim > 4) ? lim - 4 + $urandom_range(5) : $urandom_range(5);
      if (r < 80)
         return (lim > 0) ? $urandom_range(lim - 1) : 0;
      return $urandom_range(20'hFFFFF);
   endfunction

   // One request transfer. Valid may drop for a random gap first; once raised,
   // it stays up with a stable payload until the transfer completes.
   task automatic send(input req_item_type it);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_mode <= it.mode;
      req_rom_index <= it.rom_index;
      req_rom_byte <= it.rom_byte;
      req_nibble <= it.nibble;
      req_bit_count <= it.bit_count;
      do @(posedge clock); while (!req_ready);
      sb.note_transfer(it);
      items_sent++;
   endtask

   // Reads and branches must never touch a store entry that was never written,
   // so any such entry gets a random byte first.
   task automatic put(input req_item_type it);
      int unsigned idx;
      req_item_type fill;
      if (it.mode == MODE_READ || it.mode == MODE_BRANCH) begin
         while (sb.find_unwritten(it.mode, it.bit_count, idx)) begin
            fill = make(MODE_WRITE, idx[14:0], 8'($urandom_range(255)));
            send(fill);
         end
      end
      send(it);
   endtask

   // Holds the request side until every expected response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Idle point for register writes: nothing outstanding, followed by an idle wait.
   task automatic settle();
      drain();
      repeat (8) @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] len);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= LENGTH_ADDR;
      pwdata <= {16'h0, len};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.rom_length = len;
      settings_used++;
      // Read the register back in a second setup and access pair.
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {16'h0, len})
         sb.complain($sformatf("rom_length readback expected %08h actual %08h",
                               {16'h0, len}, prdata));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Directed opening at the reset limit: store extremes, reads from reset,
   // nibble saturation, and both ways a branch can run off the store.
   task automatic directed();
      logic [19:0] top;
      top = 20'h07FFF;
      put(make(MODE_WRITE, 15'h0000, 8'hA5));
      put(make(MODE_WRITE, 15'h0001, 8'h5A));
      put(make(MODE_WRITE, 15'h0002, 8'hFF));
      put(make(MODE_WRITE, 15'h7FFF, 8'h81));
      put(make(MODE_WRITE, 15'h7FFE, 8'h00));
      // From reset no bits are left, so a full read spans bytes 0 and 1.
      put(make(MODE_READ, 15'd0, 8'd8));
      // A zero-bit read with an empty byte still steps to the next one.
      put(make(MODE_READ, 15'd0, 8'd0));
      put(make(MODE_READ, 15'd0, 8'd15));
      // Six loads of all ones: the top bits fall off, the sixth is ignored.
      repeat (6) put(make(MODE_LOAD, 15'd0, 8'hF));
      // Neither byte of the word is inside the limit.
      put(make(MODE_BRANCH, 15'd0, 8'd0));
      // Past the limit, but it still clears the nibble position.
      put(make(MODE_READ, 15'd0, 8'd3));
      for (int i = 0; i < 5; i++)
         put(make(MODE_LOAD, 15'd0, {4'h0, top[4*i +: 4]}));
      // Only the high byte of the word lies inside the limit.
      put(make(MODE_BRANCH, 15'd0, 8'd0));
      // A one-bit read right after loading asks for nothing at all.
      put(make(MODE_READ, 15'd0, 8'd1));
      put(make(MODE_LOAD, 15'd0, 8'h0));
      put(make(MODE_READ, 15'd0, 8'd0));
   endtask

   // One random burst. Most bursts are an address load followed by reads, so
   // the serial position walks through real data; the rest are reads that go
   // on from where the last burst left off, store writes, and raw noise.
   task automatic random_sequence();
      int unsigned r, target, k;
      req_item_type it;
      r = $urandom_range(99);
      if (r < 55) begin
         target = pick_target();
         // A read clears a stale nibble position so the load starts at bit 0.
         if (sb.nib_pos != 5'd0)
            put(make(MODE_READ, 15'd0, 8'd0));
         k = ($urandom_range(99) < 75) ? 5 : $urandom_range(1, 7);
         for (int i = 0; i < k; i++) begin
            it = random_item(MODE_LOAD);
            if (i < 5)
               it.nibble = target[4*i +: 4];
            put(it);
         end
         repeat ($urandom_range(1, 10)) put(read_or_branch());
      end else if (r < 70) begin
         repeat ($urandom_range(1, 6)) put(read_or_branch());
      end else if (r < 85) begin
         repeat ($urandom_range(1, 4)) begin
            it = random_item(MODE_WRITE);
            if ($urandom_range(1) == 1)
               it.rom_index = sb.address[14:0] + 15'($urandom_range(3));
            put(it);
         end
      end else begin
         put(random_item(mode_type'($urandom_range(3))));
      end
      // Now and then the sender waits for the response side to run dry.
      if ($urandom_range(99) < 2)
         drain();
   endtask

   task automatic run_phase(input logic [LEN_W-1:0] len, input int unsigned idle_pct,
                            input int unsigned stall_pct, input int unsigned n);
      int unsigned stop_at;
      settle();
      write_length(len);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at = items_sent + n;
      while (items_sent < stop_at)
         random_sequence();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      directed();

      // Each phase pairs one rom_length setting with one idle pattern.
      run_phase(16'd65535, 0, 0, 130);
      run_phase(16'd300, 69, 0, 130);
      run_phase(16'd1, 0, 69, 90);
      run_phase(16'd0, 13, 13, 70);
      run_phase(16'($urandom_range(4, 4000)), 13, 13, 130);
      run_phase(16'd2, 0, 69, 90);
      run_phase(16'd32767, 69, 0, 130);
      run_phase(16'd32768, 0, 0, 130);

      // Let any stray response show up before the verdict.
      drain();
      repeat (10) @(posedge clock);
      if (sb.pending_results.size() != 0)
         sb.complain($sformatf("%0d expected responses never arrived",
                               sb.pending_results.size()));

      $display("Run covered %0d request transfers (%0d writes, %0d loads, %0d reads, %0d branches)",
               items_sent, sb.mode_count[0], sb.mode_count[1], sb.mode_count[2],
               sb.mode_count[3]);
      $display("and %0d checked responses over %0d rom_length settings from 0 to 65535.",
               sb.checked, settings_used);
      if (sb.errors == 0)
         $display("PASS serial_speech_rom_reader");
      else
         $display("FAIL serial_speech_rom_reader");
      $finish;
   end

endmodule
